FILE: rtl/set_assoc_cache_lookup_macros.svh
// Assertion macros for the cache lookup block
`ifndef SET_ASSOC_CACHE_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_LOOKUP_MACROS_SVH
// assert that a implies b on the same edge
`define SACL_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b on the next edge
`define SACL_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

FILE: rtl/sacl_pkg.sv
// Shared types and constants for the cache lookup block
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;
	localparam int NUM_SETS_DEF = 64;
	localparam int NUM_WAYS_DEF = 4;
	localparam int TAG_BITS_DEF = 20;
	localparam int IN_TAG_W = 20;
	localparam int SET_W = 6;
	localparam int CYC_W = 14;
	localparam logic [1:0] REG_WRITE_THROUGH = 2'd0;
	localparam logic [1:0] REG_RANDOM_REPLACE = 2'd1;
	localparam logic [1:0] REG_CACHE_LATENCY = 2'd2;
	localparam logic [1:0] REG_MEMORY_LATENCY = 2'd3;
	localparam logic [1:0] BUS_NONE = 2'd0;
	localparam logic [1:0] BUS_READ = 2'd1;
	localparam logic [1:0] BUS_WRITE = 2'd2;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_OUT} state_t;
	typedef struct packed {
		logic write_through;
		logic random_replace;
		logic [7:0] cache_latency;
		logic [11:0] memory_latency;
	} cfg_t;
endpackage
`default_nettype wire

FILE: rtl/sacl_set_mem.sv
// Per-set storage: valid, dirty, tags and recency order, one set a row
`timescale 1ns / 1ps
`default_nettype none
module sacl_set_mem #(
	parameter int NUM_SETS = sacl_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = sacl_pkg::NUM_WAYS_DEF,
	parameter int TAG_BITS = sacl_pkg::TAG_BITS_DEF,
	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
	localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
	input wire clk,
	input wire arst_n,
	input wire rd_en,
	input wire [SW-1:0] rd_addr,
	input wire wr_en,
	input wire [SW-1:0] wr_addr,
	input wire [NUM_WAYS-1:0] wr_valid,
	input wire [NUM_WAYS-1:0] wr_dirty,
	input wire [NUM_WAYS-1:0][TAG_BITS-1:0] wr_tag,
	input wire [NUM_WAYS-1:0][WW-1:0] wr_order,
	input wire [NUM_WAYS-1:0] wr_tag_we,
	output logic [NUM_WAYS-1:0] rd_valid,
	output logic [NUM_WAYS-1:0] rd_dirty,
	output logic [NUM_WAYS-1:0][TAG_BITS-1:0] rd_tag,
	output logic [NUM_WAYS-1:0][WW-1:0] rd_order
);
	// written flags per set live in flops so reset clears them; an unwritten set reads as reset
	logic [NUM_SETS-1:0] set_written_q;
	logic [NUM_WAYS-1:0] valid_mem [NUM_SETS];
	logic [NUM_WAYS-1:0] dirty_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][WW-1:0] order_mem [NUM_SETS];
	logic [TAG_BITS-1:0] tag_mem [NUM_WAYS][NUM_SETS];
	logic [NUM_WAYS-1:0] v_q, d_q;
	logic [NUM_WAYS-1:0][WW-1:0] o_q;
	logic wr_q;
	logic [NUM_WAYS-1:0][WW-1:0] init_order;

	always_comb begin
		for (int i = 0; i < NUM_WAYS; i++) init_order[i] = WW'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_written_q <= '0;
			wr_q <= 1'b0;
		end else begin
			if (wr_en) set_written_q[wr_addr] <= 1'b1;
			if (rd_en) wr_q <= set_written_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			valid_mem[wr_addr] <= wr_valid;
			dirty_mem[wr_addr] <= wr_dirty;
			order_mem[wr_addr] <= wr_order;
		end
		if (rd_en) begin
			v_q <= valid_mem[rd_addr];
			d_q <= dirty_mem[rd_addr];
			o_q <= order_mem[rd_addr];
		end
	end

	for (genvar g = 0; g < NUM_WAYS; g++) begin : g_tag
		always_ff @(posedge clk) begin
			if (wr_en && wr_tag_we[g]) tag_mem[g][wr_addr] <= wr_tag[g];
			if (rd_en) rd_tag[g] <= tag_mem[g][rd_addr];
		end
	end

	assign rd_valid = wr_q ? v_q : '0;
	assign rd_dirty = wr_q ? d_q : '0;
	assign rd_order = wr_q ? o_q : init_order;
endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_lookup.sv
// Cache lookup top level: control, lookup logic and result register
// Steps: set memory read, resolve, output register; the last waits while a result is held.
// One request at a time: a new one is taken only in idle, after the set read-modify-write.
// The next request is taken while a result still waits in the output register.
// Reset: all ways invalid and clean, recency in way order, LFSR 0xACE1, config to defaults.
// No clearing pass: per-set written flags make unwritten sets read as reset.
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_cache_lookup_macros.svh"
module set_assoc_cache_lookup #(
	parameter int NUM_SETS = sacl_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = sacl_pkg::NUM_WAYS_DEF,
	parameter int TAG_BITS = sacl_pkg::TAG_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	output logic s_tready,
	// tdata: set_index[5:0], tag[25:6], zero pad
	input wire [31:0] s_tdata,
	// tuser: req_type
	input wire s_tuser,
	output logic m_tvalid,
	input wire m_tready,
	// tdata: hit, eviction, dirty_eviction, cycles[16:3], bus_op[18:17], zero pad
	output logic [23:0] m_tdata,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire [1:0] cfg_index,
	input wire [31:0] cfg_data
);
	localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TB = (TAG_BITS < sacl_pkg::IN_TAG_W) ? TAG_BITS : sacl_pkg::IN_TAG_W;

	sacl_pkg::cfg_t cfg_q;
	sacl_pkg::state_t state_q, state_d;
	logic [15:0] lfsr_q;
	logic [SW-1:0] set_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic wr_s1;
	logic out_v_q;
	logic [23:0] out_q;

	logic [NUM_WAYS-1:0] rv, rd, nv, nd, twe;
	logic [NUM_WAYS-1:0][TAG_BITS-1:0] rt, nt;
	logic [NUM_WAYS-1:0][WW-1:0] ro, no;
	logic s_acc, res_go;
	logic [SW-1:0] set_in;

	assign cfg_ready = 1'b1;
	assign s_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == sacl_pkg::ST_IDLE);
	assign set_in = SW'(32'(s_tdata[5:0]) % NUM_SETS);
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{1'b0, 1'b0, 8'd1, 12'd100};
		end else if (cfg_valid) begin
			case (cfg_index)
				sacl_pkg::REG_WRITE_THROUGH: cfg_q.write_through <= cfg_data[0];
				sacl_pkg::REG_RANDOM_REPLACE: cfg_q.random_replace <= cfg_data[0];
				sacl_pkg::REG_CACHE_LATENCY: cfg_q.cache_latency <= cfg_data[7:0];
				sacl_pkg::REG_MEMORY_LATENCY: cfg_q.memory_latency <= cfg_data[11:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	sacl_set_mem #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .TAG_BITS(TAG_BITS)) u_mem (
		.clk(clk), .arst_n(arst_n),
		.rd_en(s_acc), .rd_addr(set_in),
		.wr_en(res_go), .wr_addr(set_s1),
		.wr_valid(nv), .wr_dirty(nd), .wr_tag(nt), .wr_order(no), .wr_tag_we(twe),
		.rd_valid(rv), .rd_dirty(rd), .rd_tag(rt), .rd_order(ro)
	);

	// resolve: scan positions front to back, pick hit/fill or victim
	logic hit, ev, dev, done, lfsr_adv;
	logic [1:0] bus;
	logic [13:0] cyc;
	logic [WW-1:0] pos, vw;
	logic [WW-1:0] w;
	logic [13:0] ml;
	always_comb begin
		hit = 1'b0; ev = 1'b0; dev = 1'b0; done = 1'b0; lfsr_adv = 1'b0;
		pos = '0; w = '0;
		bus = sacl_pkg::BUS_NONE;
		ml = 14'(cfg_q.memory_latency);
		cyc = 14'(cfg_q.cache_latency);
		nv = rv; nd = rd; nt = rt; no = ro; twe = '0;
		for (int p = 0; p < NUM_WAYS; p++) begin
			vw = WW'(32'(ro[p]) % NUM_WAYS);
			if (!done && (!rv[vw] || rt[vw] == tag_s1)) begin
				done = 1'b1; pos = WW'(p); w = vw;
				hit = rv[vw];
			end
		end
		if (!done) begin
			ev = 1'b1;
			if (cfg_q.random_replace) begin
				pos = WW'(32'(lfsr_q) % NUM_WAYS);
				lfsr_adv = 1'b1;
			end else begin
				pos = WW'(NUM_WAYS - 1);
			end
			w = WW'(32'(ro[pos]) % NUM_WAYS);
		end
		if (hit) begin
			if (wr_s1) begin
				if (cfg_q.write_through) cyc = cyc + ml;
				else nd[w] = 1'b1;
			end
		end else begin
			nv[w] = 1'b1; nt[w] = tag_s1; twe[w] = 1'b1;
			if (wr_s1) begin
				bus = sacl_pkg::BUS_WRITE;
				if (ev && rd[w]) begin dev = 1'b1; cyc = cyc + ml; end
				if (cfg_q.write_through) begin cyc = cyc + ml; nd[w] = 1'b0; end
				else nd[w] = 1'b1;
			end else begin
				bus = sacl_pkg::BUS_READ;
				cyc = cyc + ml;
				if (ev && !cfg_q.write_through && rd[w]) begin dev = 1'b1; cyc = cyc + ml; end
				nd[w] = 1'b0;
			end
		end
		if (!cfg_q.random_replace) begin
			for (int p = 1; p < NUM_WAYS; p++)
				if (WW'(p) <= pos) no[p] = ro[p-1];
			no[0] = ro[pos];
		end
	end

	assign res_go = (state_q == sacl_pkg::ST_LOOK);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sacl_pkg::ST_IDLE: if (s_acc) state_d = sacl_pkg::ST_LOOK;
			sacl_pkg::ST_LOOK: state_d = sacl_pkg::ST_OUT;
			sacl_pkg::ST_OUT: if (!out_v_q || m_tready) state_d = sacl_pkg::ST_IDLE;
			default: state_d = sacl_pkg::ST_IDLE;
		endcase
	end

	logic [23:0] res_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacl_pkg::ST_IDLE;
			lfsr_q <= sacl_pkg::LFSR_SEED;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_go && lfsr_adv)
				lfsr_q <= {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
			if (state_q == sacl_pkg::ST_OUT && (!out_v_q || m_tready)) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			set_s1 <= set_in;
			tag_s1 <= TAG_BITS'(s_tdata[6 +: TB]);
			wr_s1 <= s_tuser;
		end
		if (res_go) res_s2 <= {5'd0, bus, cyc, dev, ev, hit};
		if (state_q == sacl_pkg::ST_OUT && (!out_v_q || m_tready)) out_q <= res_s2;
	end

	`SACL_ASSERT_IMP(a_one_busy, clk, arst_n, res_go, !s_tready)
	`SACL_ASSERT_NXT(a_acc_look, clk, arst_n, s_acc, state_q == sacl_pkg::ST_LOOK)
	`SACL_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire
